// File: design/cicd_pkg.sv
// Shared constants, types and coefficient table of the compensated IQ decimator.
`default_nettype none
package cicd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FACTOR_BITS = 13;
    localparam int PHASE_BITS  = 12;
    localparam int MAX_FACTOR  = 4096;
    localparam int ACC_BITS    = 42;
    localparam int COEF_BITS   = 18;
    localparam int COEF_FRAC   = 17;
    localparam int TAP_COUNT   = 33;
    localparam int CNT_BITS    = 6;
    localparam int PROD_BITS   = ACC_BITS + COEF_BITS;
    localparam int SUM_BITS    = 64;
    localparam int FSQ_BITS    = 25;
    localparam int QUO_BITS    = 18;
    localparam int REM_BITS    = 66;
    localparam int DIV_STEPS   = QUO_BITS;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(32);

    typedef struct packed {
        logic integ;
        logic comb;
        logic mul;
        logic add;
        logic div_load;
        logic div_step;
    } lane_ctrl_t;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    localparam coef_t COEF_TABLE [TAP_COUNT] = '{
        -18'sd364, -18'sd66, 18'sd652, -18'sd446, -18'sd1017, 18'sd1827, 18'sd523,
        -18'sd3924, 18'sd2127, 18'sd5310, -18'sd7612, -18'sd3567, 18'sd15515,
        -18'sd4011, -18'sd26362, 18'sd21180, 18'sd65536, 18'sd21180, -18'sd26362,
        -18'sd4011, 18'sd15515, -18'sd3567, -18'sd7612, 18'sd5310, 18'sd2127,
        -18'sd3924, 18'sd523, 18'sd1827, -18'sd1017, -18'sd446, 18'sd652,
        -18'sd66, -18'sd364
    };

    function automatic coef_t coef_at(input logic [CNT_BITS-1:0] k);
        coef_t c;
        c = '0;
        if (int'(k) < TAP_COUNT)
        begin
            c = COEF_TABLE[k];
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: design/cicd_lane.sv
// One channel: integrators, combs, rotating tap line with MAC and restoring divider.
`default_nettype none
module cicd_lane
    import cicd_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] sample,
    input  wire lane_ctrl_t                    ctrl,
    input  wire coef_t                         coef,
    input  wire logic [FSQ_BITS-1:0]           fsq,
    output logic signed [SAMPLE_BITS-1:0]      result
);

    logic [ACC_BITS-1:0] int1_reg, int2_reg;
    logic [ACC_BITS-1:0] d1_reg [2];
    logic [ACC_BITS-1:0] d2_reg [2];
    logic signed [ACC_BITS-1:0] tap_reg [TAP_COUNT];
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [SUM_BITS-1:0] acc_reg;
    logic [REM_BITS-1:0] rem_reg, dsh_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic neg_reg;

    logic [ACC_BITS-1:0] int1_next, c1, c2;
    logic [SUM_BITS-1:0] mag;

    assign int1_next = int1_reg + {{(ACC_BITS-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    assign c1 = int2_reg - d1_reg[1];
    assign c2 = c1 - d2_reg[1];
    assign mag = acc_reg[SUM_BITS-1] ? SUM_BITS'(-acc_reg) : SUM_BITS'(acc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int1_reg <= '0;
            int2_reg <= '0;
            d1_reg[0] <= '0;
            d1_reg[1] <= '0;
            d2_reg[0] <= '0;
            d2_reg[1] <= '0;
            for (int k = 0; k < TAP_COUNT; k++)
            begin
                tap_reg[k] <= '0;
            end
        end
        else
        begin
            if (ctrl.integ)
            begin
                int1_reg <= int1_next;
                int2_reg <= int2_reg + int1_next;
            end
            if (ctrl.comb)
            begin
                d1_reg[1] <= d1_reg[0];
                d1_reg[0] <= int2_reg;
                d2_reg[1] <= d2_reg[0];
                d2_reg[0] <= c1;
                for (int k = 0; k < TAP_COUNT - 1; k++)
                begin
                    tap_reg[k] <= tap_reg[k+1];
                end
                tap_reg[TAP_COUNT-1] <= c2;
            end
            else if (ctrl.mul)
            begin
                for (int k = 0; k < TAP_COUNT - 1; k++)
                begin
                    tap_reg[k] <= tap_reg[k+1];
                end
                tap_reg[TAP_COUNT-1] <= tap_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul)
        begin
            prod_reg <= tap_reg[0] * coef;
        end
        if (ctrl.comb)
        begin
            acc_reg <= '0;
        end
        else if (ctrl.add)
        begin
            acc_reg <= acc_reg + {{(SUM_BITS-PROD_BITS){prod_reg[PROD_BITS-1]}}, prod_reg};
        end
        if (ctrl.div_load)
        begin
            neg_reg <= acc_reg[SUM_BITS-1];
            rem_reg <= {2'b00, mag} + (REM_BITS'(fsq) << (COEF_FRAC + 1));
            dsh_reg <= REM_BITS'(fsq) << (COEF_FRAC + 2 + QUO_BITS - 1);
            quo_reg <= '0;
        end
        else if (ctrl.div_step)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b1};
            end
            else
            begin
                quo_reg <= {quo_reg[QUO_BITS-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > QUO_BITS'(32768))
            begin
                result = 16'sh8000;
            end
            else
            begin
                result = -$signed(quo_reg[SAMPLE_BITS-1:0]);
            end
        end
        else
        begin
            if (quo_reg > QUO_BITS'(32767))
            begin
                result = 16'sh7fff;
            end
            else
            begin
                result = $signed(quo_reg[SAMPLE_BITS-1:0]);
            end
        end
    end

endmodule
`default_nettype wire

// File: design/cic_compensated_iq_decimator.sv
// Top level: handshake, decimation phase, sequencer, I and Q lanes and output register.
// An item that is not a decimation instant only updates the integrators and the phase.
// A decimation instant runs through the accepting handshake, a comb update, a multiply-accumulate
// pass over the taps on the multiplier of each lane, the bit-serial divider and the load into the
// output register, which waits while the previous output item still waits for the receiver.
// Reset is asynchronous and clears the integrator, comb and tap state; the factor returns to 32.
`default_nettype none
module cic_compensated_iq_decimator
    import cicd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [31:0]            s_axis_tdata,  // i_sample, q_sample
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // i_out, q_out
    input  wire logic                   cfg_we,
    input  wire logic [FACTOR_BITS-1:0] cfg_wdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_COMB = 5'b00010,
        S_MAC  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [FACTOR_BITS-1:0] factor_reg;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [FSQ_BITS-1:0] fsq_reg;
    logic out_valid_reg;
    logic [31:0] out_data_reg;

    logic [FACTOR_BITS-1:0] factor_eff;
    logic [FACTOR_BITS-1:0] phase_inc;
    logic accept, dec, load_out;
    lane_ctrl_t ctrl;
    logic signed [SAMPLE_BITS-1:0] i_res, q_res;
    coef_t coef;

    assign factor_eff = (factor_reg > FACTOR_BITS'(MAX_FACTOR)) ? FACTOR_BITS'(MAX_FACTOR)
                                                                 : factor_reg;
    assign phase_inc = FACTOR_BITS'(phase_reg) + FACTOR_BITS'(1);
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready && (factor_reg != '0);
    assign dec = accept && (phase_inc >= factor_eff);
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);
    assign coef = coef_at(cnt_reg);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;

    always_comb
    begin
        ctrl = '0;
        ctrl.integ = accept;
        ctrl.comb = (state_reg == S_COMB);
        ctrl.mul = (state_reg == S_MAC) && (int'(cnt_reg) < TAP_COUNT);
        ctrl.add = (state_reg == S_MAC) && (cnt_reg != '0);
        ctrl.div_load = (state_reg == S_DIV) && (cnt_reg == '0);
        ctrl.div_step = (state_reg == S_DIV) && (cnt_reg != '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (dec)
                begin
                    state_next = S_COMB;
                end
            end
            S_COMB: state_next = S_MAC;
            S_MAC:
            begin
                if (int'(cnt_reg) == TAP_COUNT)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (int'(cnt_reg) == DIV_STEPS)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            factor_reg <= FACTOR_RESET;
            phase_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                factor_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= dec ? '0 : phase_inc[PHASE_BITS-1:0];
            end
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CNT_BITS'(1);
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fsq_reg <= FSQ_BITS'(factor_eff) * FSQ_BITS'(factor_eff);
        if (load_out)
        begin
            out_data_reg <= {q_res, i_res};
        end
    end

    cicd_lane u_lane_i (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (s_axis_tdata[15:0]),
        .ctrl   (ctrl),
        .coef   (coef),
        .fsq    (fsq_reg),
        .result (i_res)
    );

    cicd_lane u_lane_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (s_axis_tdata[31:16]),
        .ctrl   (ctrl),
        .coef   (coef),
        .fsq    (fsq_reg),
        .result (q_res)
    );

endmodule
`default_nettype wire
